/* rtl/eftx_pkg.sv */
package eftx_pkg;

   // frame delimiters and escape codes
   localparam logic [7:0] FRAME_HEAD = 8'hFD;
   localparam logic [7:0] FRAME_ESC  = 8'hFE;
   localparam logic [7:0] FRAME_TAIL = 8'hF8;
   localparam logic [7:0] ESC_HEAD   = 8'h7D;
   localparam logic [7:0] ESC_ESC    = 8'h7E;
   localparam logic [7:0] ESC_TAIL   = 8'h78;
   localparam logic [7:0] ESC_NONE   = 8'h00;

   // request opcodes
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_COMMIT = 2'd1;
   localparam logic [1:0] OP_READY  = 2'd2;

   localparam int ERR_W  = 16;
   localparam int USED_W = 6;

   typedef struct packed {
      logic put;
      logic take;
   } ring_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_stat_type;

   // second byte of an escape pair, ESC_NONE when the byte goes out as is
   function automatic logic [7:0] esc_code(input logic [7:0] b);
      logic [7:0] code;
      code = ESC_NONE;
      if (b == FRAME_HEAD) begin
         code = ESC_HEAD;
      end else if (b == FRAME_ESC) begin
         code = ESC_ESC;
      end else if (b == FRAME_TAIL) begin
         code = ESC_TAIL;
      end
      return code;
   endfunction

endpackage

/* rtl/eftx_ram.sv */
module eftx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/eftx_ring.sv */
module eftx_ring
   import eftx_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ring_ctrl_type          ctrl,
   input  logic [7:0]             put_byte,
   output ring_stat_type          stat,
   output logic [7:0]             take_byte,
   output logic [$clog2(DEPTH):0] used
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_next, wr_next;

   // pointers name the last entry read / written; equal means empty
   assign rd_next = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_next = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;

   assign stat.empty = (rd_ptr_ff == wr_ptr_ff);
   assign stat.full  = (wr_next == rd_ptr_ff);

   assign rd_ptr_in = ctrl.take ? rd_next : rd_ptr_ff;
   assign wr_ptr_in = ctrl.put  ? wr_next : wr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_comb begin
      used = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      if (wr_ptr_ff < rd_ptr_ff) begin
         used = used + (AW+1)'(DEPTH);
      end
   end

   eftx_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock (clock),
      .we    (ctrl.put),
      .waddr (wr_next),
      .wdata (put_byte),
      .re    (ctrl.take),
      .raddr (rd_next),
      .rdata (take_byte)
   );

`ifndef SYNTH
   a_put_not_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.put |-> !stat.full)
      else $error("ring write while full");

   a_take_not_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.take |-> !stat.empty)
      else $error("ring read while empty");

   a_no_put_and_take: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.put && ctrl.take))
      else $error("ring written and read in one cycle");
`endif

endmodule

/* rtl/escaped_frame_tx_ring_buffer.sv */
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_opcode, req_payload_byte
// rsp_      out        rsp_valid / rsp_stall  rsp_out_valid, rsp_out_byte,
//                                             rsp_error_count, rsp_ring_used
//
// One request at a time. Push runs S_EXEC then S_EMIT, with S_ESC2 between if
// the byte is escaped (one staging write port); ready and unused opcodes run
// S_EXEC then S_EMIT; a good commit adds S_COPY (one ring write per cycle,
// staging read one ahead). Reset is synchronous; no clearing pass, both stores
// start empty. A stalled result holds the block in its final state; the next
// request is taken once that result moves into the output register.
module escaped_frame_tx_ring_buffer
   import eftx_pkg::*;
#(
   parameter int BUF_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_payload_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_out_valid,
   output logic [7:0]        rsp_out_byte,
   output logic [ERR_W-1:0]  rsp_error_count,
   output logic [USED_W-1:0] rsp_ring_used
);

   localparam int AW = $clog2(BUF_DEPTH);
   // counts that must reach BUF_DEPTH itself
   localparam int CW = $clog2(BUF_DEPTH + 1);
   // room for length + 4 without wrap
   localparam int LW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C  = CW'(BUF_DEPTH);
   localparam logic [LW-1:0] DEPTH_L  = LW'(BUF_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_ESC2 = 3'd2;
   localparam logic [2:0] S_COPY = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [7:0]       byte_ff, byte_in;
   logic [CW-1:0]    len_ff, len_in;      // header slot + stuffed payload
   logic [CW-1:0]    cnt_ff, cnt_in;      // raw payload bytes, saturating
   logic [7:0]       sum_ff, sum_in;
   logic             ovf_ff, ovf_in;
   logic [ERR_W-1:0] err_ff, err_in;
   logic [CW-1:0]    idx_ff, idx_in;      // frame byte being copied
   logic             hit_ff, hit_in;      // ready found a byte

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ov_ff, rsp_ov_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;

   // staging store port
   logic          stg_we;
   logic [AW-1:0] stg_waddr;
   logic [7:0]    stg_wdata;
   logic          stg_re;
   logic [AW-1:0] stg_raddr;
   logic [7:0]    stg_rdata;

   // ring port
   ring_ctrl_type ring_ctrl;
   ring_stat_type ring_stat;
   logic [7:0]    ring_put;
   logic [7:0]    ring_take;
   logic [AW:0]   ring_used;
   logic [AW+USED_W:0] used_wide;

   // push decode
   logic [7:0]    second;
   logic          has_esc;
   logic          cnt_full;
   logic [LW-1:0] len_need;
   logic          push_ovf;
   logic          frame_bad;
   logic          can_emit;

   assign second   = esc_code(byte_ff);
   assign has_esc  = (second != ESC_NONE);
   assign cnt_full = (cnt_ff >= DEPTH_C);
   // length + need + 2 must stay below the depth
   assign len_need = LW'(len_ff) + (has_esc ? LW'(4) : LW'(3));
   assign push_ovf = ovf_ff || cnt_full || (len_need >= DEPTH_L);
   assign frame_bad = ovf_ff || cnt_full || ((LW'(len_ff) + LW'(2)) >= DEPTH_L);
   assign can_emit = !rsp_valid_ff || !rsp_stall;

   assign used_wide = {{USED_W{1'b0}}, ring_used};

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      byte_in   = byte_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      ovf_in    = ovf_ff;
      err_in    = err_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ov_in    = rsp_ov_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_used_in  = rsp_used_ff;

      stg_we    = 1'b0;
      stg_waddr = len_ff[AW-1:0];
      stg_wdata = byte_ff;
      stg_re    = 1'b0;
      stg_raddr = idx_ff[AW-1:0] + 1'b1;

      ring_ctrl.put  = 1'b0;
      ring_ctrl.take = 1'b0;
      ring_put       = FRAME_HEAD;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               byte_in  = req_payload_byte;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            hit_in   = 1'b0;
            state_in = S_EMIT;
            unique case (op_ff)
               OP_PUSH: begin
                  sum_in = sum_ff + byte_ff;
                  if (!cnt_full) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  if (push_ovf) begin
                     ovf_in = 1'b1;
                  end else begin
                     // escaped bytes take a second write next cycle
                     stg_we    = 1'b1;
                     stg_wdata = has_esc ? FRAME_ESC : byte_ff;
                     len_in    = len_ff + (has_esc ? CW'(2) : CW'(1));
                     if (has_esc) begin
                        state_in = S_ESC2;
                     end
                  end
               end
               OP_COMMIT: begin
                  if (frame_bad) begin
                     err_in = err_ff + 1'b1;
                     len_in = CW'(1);
                     cnt_in = '0;
                     sum_in = '0;
                     ovf_in = 1'b0;
                  end else begin
                     idx_in   = '0;
                     state_in = S_COPY;
                  end
               end
               OP_READY: begin
                  if (!ring_stat.empty) begin
                     ring_ctrl.take = 1'b1;
                     hit_in         = 1'b1;
                  end
               end
               default: begin
                  // unused opcode: status only
               end
            endcase
         end

         S_ESC2: begin
            // len_ff already counts both bytes of the pair
            stg_we    = 1'b1;
            stg_waddr = len_ff[AW-1:0] - 1'b1;
            stg_wdata = second;
            state_in  = S_EMIT;
         end

         S_COPY: begin
            // fetch the next staged byte while this one goes to the ring
            stg_re = 1'b1;
            if (idx_ff == '0) begin
               ring_put = FRAME_HEAD;
            end else if (idx_ff < len_ff) begin
               ring_put = stg_rdata;
            end else if (idx_ff == len_ff) begin
               ring_put = sum_ff;
            end else begin
               ring_put = FRAME_TAIL;
            end
            if (ring_stat.full) begin
               // truncated: copied bytes stay queued
               err_in   = err_ff + 1'b1;
               len_in   = CW'(1);
               cnt_in   = '0;
               sum_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_EMIT;
            end else begin
               ring_ctrl.put = 1'b1;
               if (idx_ff == len_ff + 1'b1) begin
                  len_in   = CW'(1);
                  cnt_in   = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = S_EMIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_EMIT: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_ov_in    = hit_ff;
               rsp_byte_in  = hit_ff ? ring_take : 8'h00;
               rsp_err_in   = err_ff;
               rsp_used_in  = used_wide[USED_W-1:0];
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= CW'(1);
         cnt_ff       <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         err_ff       <= '0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         err_ff       <= err_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      byte_ff     <= byte_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_valid   = rsp_ov_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_error_count = rsp_err_ff;
   assign rsp_ring_used   = rsp_used_ff;

   // staging store: entry 0 is the header slot and is never read back
   eftx_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_stage_ram (
      .clock (clock),
      .we    (stg_we),
      .waddr (stg_waddr),
      .wdata (stg_wdata),
      .re    (stg_re),
      .raddr (stg_raddr),
      .rdata (stg_rdata)
   );

   eftx_ring #(
      .DEPTH (BUF_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ring_ctrl),
      .put_byte  (ring_put),
      .stat      (ring_stat),
      .take_byte (ring_take),
      .used      (ring_used)
   );

`ifndef SYNTH
   a_len_fits: assert property (@(posedge clock) disable iff (reset)
      !ovf_ff |-> ((LW'(len_ff) + LW'(2)) < DEPTH_L))
      else $error("staged frame longer than the store");

   a_copy_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY) |-> !ovf_ff)
      else $error("overflowed frame being copied");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("result raised outside emit");
`endif

endmodule
